// File: src/ssrg_pkg.sv
// ----------------------------------------------------------------------------
// Stepper ramp generator package
// Shared widths, operation and register codes, and reset values.
// ----------------------------------------------------------------------------
`default_nettype none

package ssrg_pkg;

   // Width of the pending, position and target counters.
   localparam int COUNT_WIDTH = 32;

   // Field widths of the channels.
   localparam int OP_WIDTH        = 2;
   localparam int AMOUNT_WIDTH    = 32;
   localparam int OUT_COUNT_WIDTH = 32;
   localparam int SPEED_WIDTH     = 16;
   localparam int LIMIT_WIDTH     = 15;
   localparam int NUMER_WIDTH     = 24;
   localparam int RELOAD_WIDTH    = 16;
   localparam int CSR_INDEX_WIDTH = 3;
   localparam int CSR_DATA_WIDTH  = 24;

   // Reset values of the configuration registers and of the reload.
   localparam logic [LIMIT_WIDTH-1:0]  LIMIT_RESET   = LIMIT_WIDTH'(2000);
   localparam logic [NUMER_WIDTH-1:0]  NUMER_RESET   = NUMER_WIDTH'(200000);
   localparam logic [RELOAD_WIDTH-1:0] CEILING_RESET = RELOAD_WIDTH'(65535);
   localparam logic [RELOAD_WIDTH-1:0] RELOAD_RESET  = RELOAD_WIDTH'(65535);

   // Operation codes of an input transaction.
   typedef enum logic [OP_WIDTH-1:0] {
      OP_STEP  = 2'd0,
      OP_ADD   = 2'd1,
      OP_TRACK = 2'd2,
      OP_CLEAR = 2'd3
   } op_type;

   // Configuration register indexes.
   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_HOLD_ENABLE  = 3'd0,
      CSR_TRACK_ENABLE = 3'd1,
      CSR_SPEED_LIMIT  = 3'd2,
      CSR_NUMERATOR    = 3'd3,
      CSR_CEILING      = 3'd4
   } csr_index_type;

endpackage

`default_nettype wire

// File: src/ssrg_req_if.sv
// ----------------------------------------------------------------------------
// Request channel
// Valid/ready channel carrying one ramp command per transaction.
// ----------------------------------------------------------------------------
`default_nettype none

interface ssrg_req_if;
   logic                                     valid;
   logic                                     ready;
   logic [ssrg_pkg::OP_WIDTH-1:0]            op;
   logic signed [ssrg_pkg::AMOUNT_WIDTH-1:0] add_amount;

   modport source (output valid, output op, output add_amount, input ready);
   modport sink   (input valid, input op, input add_amount, output ready);
endinterface

`default_nettype wire

// File: src/ssrg_rsp_if.sv
// ----------------------------------------------------------------------------
// Response channel
// Valid/ready channel carrying the axis status after each command.
// ----------------------------------------------------------------------------
`default_nettype none

interface ssrg_rsp_if;
   logic                                        valid;
   logic                                        ready;
   logic                                        step_pulse;
   logic                                        dir_forward;
   logic [ssrg_pkg::RELOAD_WIDTH-1:0]           reload_value;
   logic signed [ssrg_pkg::OUT_COUNT_WIDTH-1:0] position_now;
   logic signed [ssrg_pkg::OUT_COUNT_WIDTH-1:0] pending_steps;
   logic signed [ssrg_pkg::SPEED_WIDTH-1:0]     speed_now;
   logic signed [ssrg_pkg::OUT_COUNT_WIDTH-1:0] target_now;

   modport source (output valid, output step_pulse, output dir_forward, output reload_value,
                   output position_now, output pending_steps, output speed_now,
                   output target_now, input ready);
   modport sink   (input valid, input step_pulse, input dir_forward, input reload_value,
                   input position_now, input pending_steps, input speed_now,
                   input target_now, output ready);
endinterface

`default_nettype wire

// File: src/ssrg_csr_if.sv
// ----------------------------------------------------------------------------
// Configuration write channel
// Valid/ready channel carrying a register index and write data.
// ----------------------------------------------------------------------------
`default_nettype none

interface ssrg_csr_if;
   logic                                   valid;
   logic                                   ready;
   logic [ssrg_pkg::CSR_INDEX_WIDTH-1:0]   index;
   logic [ssrg_pkg::CSR_DATA_WIDTH-1:0]    data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// File: src/stepper_ramp_step_generator.sv
// ----------------------------------------------------------------------------
// Stepper ramp step generator
// Single-axis linear ramp: pending queue, ramp speed, position and reload.
// ----------------------------------------------------------------------------
// Usage:
//   req carries one command per transaction: step tick, add steps, track tick
//   or state clear. Add, track and step act only while hold_enable is set.
//   rsp returns exactly one status transaction per command, reporting the
//   state after it. csr writes the five configuration registers; writing
//   hold_enable also clears the axis state. csr is always ready and must be
//   used only while the block is idle.
//   Order: most commands pass from S_IDLE through S_REPORT into the status
//   register. A step tick that issues a step first runs the bit-serial
//   divider in S_DIV, one quotient bit per cycle over the 24-bit numerator, and
//   then reports through S_REPORT as well.
//   A new command is taken only in S_IDLE, so the block is through with
//   the last command before it takes another.
//   A new command is taken while a finished status waits, once the status
//   register is free at that edge; a stalled receiver holds rsp unchanged
//   and req stays not ready until rsp is taken.
//   Reset (synchronous, active high) loads the register defaults and clears
//   the counters, speed and direction; reload starts at 65535.
// ----------------------------------------------------------------------------
`default_nettype none

module stepper_ramp_step_generator (
   input wire logic clock,
   input wire logic reset,
   ssrg_req_if.sink   req_if,
   ssrg_rsp_if.source rsp_if,
   ssrg_csr_if.sink   csr_if
);

   localparam int CW = ssrg_pkg::COUNT_WIDTH;
   localparam int SW = ssrg_pkg::SPEED_WIDTH;
   localparam int LW = ssrg_pkg::LIMIT_WIDTH;
   localparam int RW = ssrg_pkg::RELOAD_WIDTH;
   localparam int NW = ssrg_pkg::NUMER_WIDTH;
   localparam int OW = ssrg_pkg::OUT_COUNT_WIDTH;

   typedef enum logic [1:0] {
      S_IDLE,
      S_DIV,
      S_REPORT
   } state_type;

   state_type            state_ff, state_in;

   // Configuration registers.
   logic                 hold_ff,    hold_in;
   logic                 track_ff,   track_in;
   logic [LW-1:0]        limit_ff,   limit_in;
   logic [NW-1:0]        numer_ff,   numer_in;
   logic [RW-1:0]        ceiling_ff, ceiling_in;

   // Axis state.
   logic [CW-1:0]        pending_ff, pending_in;
   logic [CW-1:0]        position_ff, position_in;
   logic [CW-1:0]        target_ff,  target_in;
   logic signed [SW-1:0] speed_ff,   speed_in;
   logic                 dir_ff,     dir_in;
   logic [RW-1:0]        reload_ff,  reload_in;
   logic                 pulse_ff,   pulse_in;

   // Response register.
   logic                 rsp_valid_ff,    rsp_valid_in;
   logic                 rsp_pulse_ff,    rsp_pulse_in;
   logic                 rsp_dir_ff,      rsp_dir_in;
   logic [RW-1:0]        rsp_reload_ff,   rsp_reload_in;
   logic [OW-1:0]        rsp_position_ff, rsp_position_in;
   logic [OW-1:0]        rsp_pending_ff,  rsp_pending_in;
   logic [SW-1:0]        rsp_speed_ff,    rsp_speed_in;
   logic [OW-1:0]        rsp_target_ff,   rsp_target_in;

   // Ramp datapath.
   logic                 accept;
   logic [CW-1:0]        amount_ext;
   logic signed [CW-1:0] queue;
   logic signed [CW-1:0] speed_ext;
   logic signed [SW:0]   sp_cur;
   logic signed [SW:0]   sp_step;
   logic signed [SW:0]   sp_lim;
   logic signed [SW:0]   sp_new;
   logic [SW:0]          sp_mag;

   // Divider hookup.
   logic                 div_start;
   logic                 div_done;
   logic [NW-1:0]        div_quotient;

   ssrg_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (numer_ff),
      .divisor  (sp_mag[LW-1:0]),
      .done     (div_done),
      .quotient (div_quotient)
   );

   assign req_if.ready = (state_ff == S_IDLE) && (!rsp_valid_ff || rsp_if.ready);
   assign accept       = req_if.valid && req_if.ready;
   assign csr_if.ready = 1'b1;

   // Speed ramp: one unit toward a nonempty queue, else zero -1..1; then clamp.
   always_comb begin
      queue      = $signed(pending_ff);
      speed_ext  = CW'(speed_ff);
      sp_cur     = (SW+1)'(speed_ff);
      sp_lim     = $signed({2'b00, limit_ff});
      amount_ext = CW'(req_if.add_amount);

      if (queue == '0) begin
         sp_step = (sp_cur >= -(SW+1)'(1) && sp_cur <= (SW+1)'(1)) ? '0 : sp_cur;
      end else if (queue > CW'(0)) begin
         sp_step = (speed_ext >= queue) ? sp_cur - (SW+1)'(1) : sp_cur + (SW+1)'(1);
      end else begin
         sp_step = (queue >= speed_ext) ? sp_cur + (SW+1)'(1) : sp_cur - (SW+1)'(1);
      end

      if (sp_step > sp_lim) begin
         sp_new = sp_lim;
      end else if (sp_step < -sp_lim) begin
         sp_new = -sp_lim;
      end else begin
         sp_new = sp_step;
      end

      sp_mag = (sp_new < (SW+1)'(0)) ? $unsigned(-sp_new) : $unsigned(sp_new);
   end

   // Next-state logic for configuration, axis state and the response.
   always_comb begin
      state_in        = state_ff;
      hold_in         = hold_ff;
      track_in        = track_ff;
      limit_in        = limit_ff;
      numer_in        = numer_ff;
      ceiling_in      = ceiling_ff;
      pending_in      = pending_ff;
      position_in     = position_ff;
      target_in       = target_ff;
      speed_in        = speed_ff;
      dir_in          = dir_ff;
      reload_in       = reload_ff;
      pulse_in        = pulse_ff;
      div_start       = 1'b0;
      rsp_valid_in    = rsp_valid_ff;
      rsp_pulse_in    = rsp_pulse_ff;
      rsp_dir_in      = rsp_dir_ff;
      rsp_reload_in   = rsp_reload_ff;
      rsp_position_in = rsp_position_ff;
      rsp_pending_in  = rsp_pending_ff;
      rsp_speed_in    = rsp_speed_ff;
      rsp_target_in   = rsp_target_ff;

      // Status leaves the response register.
      if (rsp_valid_ff && rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end

      // Configuration writes; hold_enable also clears the axis state.
      if (csr_if.valid) begin
         case (csr_if.index)
            ssrg_pkg::CSR_HOLD_ENABLE: begin
               hold_in     = csr_if.data[0];
               pending_in  = '0;
               position_in = '0;
               target_in   = '0;
               speed_in    = '0;
               dir_in      = 1'b0;
               reload_in   = ssrg_pkg::RELOAD_RESET;
            end
            ssrg_pkg::CSR_TRACK_ENABLE: track_in   = csr_if.data[0];
            ssrg_pkg::CSR_SPEED_LIMIT:  limit_in   = csr_if.data[LW-1:0];
            ssrg_pkg::CSR_NUMERATOR:    numer_in   = csr_if.data[NW-1:0];
            ssrg_pkg::CSR_CEILING:      ceiling_in = csr_if.data[RW-1:0];
            default: ;
         endcase
      end

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in = S_REPORT;
               pulse_in = 1'b0;
               unique case (ssrg_pkg::op_type'(req_if.op))
                  ssrg_pkg::OP_CLEAR: begin
                     pending_in  = '0;
                     position_in = '0;
                     target_in   = '0;
                     speed_in    = '0;
                     dir_in      = 1'b0;
                     reload_in   = ssrg_pkg::RELOAD_RESET;
                  end
                  ssrg_pkg::OP_ADD: begin
                     if (hold_ff) begin
                        target_in  = target_ff + amount_ext;
                        pending_in = pending_ff + amount_ext;
                     end
                  end
                  ssrg_pkg::OP_TRACK: begin
                     if (hold_ff && track_ff) begin
                        target_in  = target_ff + CW'(1);
                        pending_in = pending_ff + CW'(1);
                     end
                  end
                  ssrg_pkg::OP_STEP: begin
                     if (hold_ff) begin
                        speed_in = sp_new[SW-1:0];
                        if (sp_new == '0) begin
                           reload_in = ceiling_ff;
                        end else begin
                           // Issue the step now; the reload follows the divide.
                           pulse_in  = 1'b1;
                           div_start = 1'b1;
                           state_in  = S_DIV;
                           if (sp_new > (SW+1)'(0)) begin
                              dir_in      = 1'b1;
                              pending_in  = pending_ff - CW'(1);
                              position_in = position_ff + CW'(1);
                           end else begin
                              dir_in      = 1'b0;
                              pending_in  = pending_ff + CW'(1);
                              position_in = position_ff - CW'(1);
                           end
                        end
                     end
                  end
               endcase
            end
         end
         S_DIV: begin
            // Saturate the quotient at the ceiling.
            if (div_done) begin
               reload_in = (div_quotient > NW'(ceiling_ff)) ? ceiling_ff
                                                           : div_quotient[RW-1:0];
               state_in  = S_REPORT;
            end
         end
         S_REPORT: begin
            rsp_valid_in    = 1'b1;
            rsp_pulse_in    = pulse_ff;
            rsp_dir_in      = dir_ff;
            rsp_reload_in   = reload_ff;
            rsp_position_in = OW'(position_ff);
            rsp_pending_in  = OW'(pending_ff);
            rsp_speed_in    = speed_ff;
            rsp_target_in   = OW'(target_ff);
            state_in        = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // State, configuration and response registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         hold_ff      <= 1'b0;
         track_ff     <= 1'b0;
         limit_ff     <= ssrg_pkg::LIMIT_RESET;
         numer_ff     <= ssrg_pkg::NUMER_RESET;
         ceiling_ff   <= ssrg_pkg::CEILING_RESET;
         pending_ff   <= '0;
         position_ff  <= '0;
         target_ff    <= '0;
         speed_ff     <= '0;
         dir_ff       <= 1'b0;
         reload_ff    <= ssrg_pkg::RELOAD_RESET;
         pulse_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         hold_ff      <= hold_in;
         track_ff     <= track_in;
         limit_ff     <= limit_in;
         numer_ff     <= numer_in;
         ceiling_ff   <= ceiling_in;
         pending_ff   <= pending_in;
         position_ff  <= position_in;
         target_ff    <= target_in;
         speed_ff     <= speed_in;
         dir_ff       <= dir_in;
         reload_ff    <= reload_in;
         pulse_ff     <= pulse_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_pulse_ff    <= rsp_pulse_in;
      rsp_dir_ff      <= rsp_dir_in;
      rsp_reload_ff   <= rsp_reload_in;
      rsp_position_ff <= rsp_position_in;
      rsp_pending_ff  <= rsp_pending_in;
      rsp_speed_ff    <= rsp_speed_in;
      rsp_target_ff   <= rsp_target_in;
   end

   assign rsp_if.valid         = rsp_valid_ff;
   assign rsp_if.step_pulse    = rsp_pulse_ff;
   assign rsp_if.dir_forward   = rsp_dir_ff;
   assign rsp_if.reload_value  = rsp_reload_ff;
   assign rsp_if.position_now  = $signed(rsp_position_ff);
   assign rsp_if.pending_steps = $signed(rsp_pending_ff);
   assign rsp_if.speed_now     = $signed(rsp_speed_ff);
   assign rsp_if.target_now    = $signed(rsp_target_ff);

endmodule

`default_nettype wire

// File: src/ssrg_div.sv
// ----------------------------------------------------------------------------
// Bit-serial divider
// Restoring division of the reload numerator by the speed magnitude, one
// quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module ssrg_div (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               start,
   input  wire logic [ssrg_pkg::NUMER_WIDTH-1:0]   dividend,
   input  wire logic [ssrg_pkg::LIMIT_WIDTH-1:0]   divisor,
   output      logic                               done,
   output      logic [ssrg_pkg::NUMER_WIDTH-1:0]   quotient
);

   localparam int STEPS     = ssrg_pkg::NUMER_WIDTH;
   localparam int CNT_WIDTH = $clog2(STEPS);
   localparam int REM_WIDTH = ssrg_pkg::LIMIT_WIDTH + 1;

   logic                                 busy_ff,  busy_in;
   logic                                 done_ff,  done_in;
   logic [CNT_WIDTH-1:0]                 count_ff, count_in;
   logic [ssrg_pkg::LIMIT_WIDTH-1:0]     rem_ff,   rem_in;
   logic [ssrg_pkg::LIMIT_WIDTH-1:0]     dsor_ff,  dsor_in;
   logic [ssrg_pkg::NUMER_WIDTH-1:0]     quo_ff,   quo_in;
   logic [REM_WIDTH-1:0]                 rem_shift;
   logic [REM_WIDTH-1:0]                 rem_diff;
   logic                                 fits;

   // One restoring step: bring down the next dividend bit and try a subtract.
   always_comb begin
      rem_shift = {rem_ff, quo_ff[ssrg_pkg::NUMER_WIDTH-1]};
      rem_diff  = rem_shift - {1'b0, dsor_ff};
      fits      = rem_shift >= {1'b0, dsor_ff};

      busy_in  = busy_ff;
      done_in  = 1'b0;
      count_in = count_ff;
      rem_in   = rem_ff;
      dsor_in  = dsor_ff;
      quo_in   = quo_ff;

      if (start) begin
         busy_in  = 1'b1;
         count_in = '0;
         rem_in   = '0;
         dsor_in  = divisor;
         quo_in   = dividend;
      end else if (busy_ff) begin
         rem_in   = fits ? rem_diff[ssrg_pkg::LIMIT_WIDTH-1:0]
                         : rem_shift[ssrg_pkg::LIMIT_WIDTH-1:0];
         quo_in   = {quo_ff[ssrg_pkg::NUMER_WIDTH-2:0], fits};
         count_in = count_ff + CNT_WIDTH'(1);
         if (count_ff == CNT_WIDTH'(STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // Control state is reset; the datapath registers are not.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      count_ff <= count_in;
      rem_ff   <= rem_in;
      dsor_ff  <= dsor_in;
      quo_ff   <= quo_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

`default_nettype wire

// File: tb/sv/stepper_ramp_step_generator_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Stepper ramp step generator testbench
// Drives ramp commands and register writes into the block with random gaps
// and receiver stalls. Each status transaction is checked field by field
// against an axis predictor kept in step with every accepted command.
// ----------------------------------------------------------------------------
`default_nettype none

module stepper_ramp_step_generator_tb;

   localparam int COUNT_WIDTH     = ssrg_pkg::COUNT_WIDTH;
   localparam int AMOUNT_WIDTH    = ssrg_pkg::AMOUNT_WIDTH;
   localparam int OUT_COUNT_WIDTH = ssrg_pkg::OUT_COUNT_WIDTH;
   localparam int SPEED_WIDTH     = ssrg_pkg::SPEED_WIDTH;
   localparam int LIMIT_WIDTH     = ssrg_pkg::LIMIT_WIDTH;
   localparam int NUMER_WIDTH     = ssrg_pkg::NUMER_WIDTH;
   localparam int RELOAD_WIDTH    = ssrg_pkg::RELOAD_WIDTH;
   localparam int CSR_INDEX_WIDTH = ssrg_pkg::CSR_INDEX_WIDTH;
   localparam int CSR_DATA_WIDTH  = ssrg_pkg::CSR_DATA_WIDTH;

   localparam int RANDOM_ITEMS   = 750;
   localparam int CALM_ITEMS     = 150;
   localparam int QUIET_LIMIT    = 2000;
   localparam int TAIL_CYCLES    = 60;
   localparam int RESET_CYCLES   = 7;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_UNUSED = 3'd7;

   // One status transaction as the block reports it.
   typedef struct packed {
      logic                       step_pulse;
      logic                       dir_forward;
      logic [RELOAD_WIDTH-1:0]    reload_value;
      logic [OUT_COUNT_WIDTH-1:0] position_now;
      logic [OUT_COUNT_WIDTH-1:0] pending_steps;
      logic [SPEED_WIDTH-1:0]     speed_now;
      logic [OUT_COUNT_WIDTH-1:0] target_now;
   } axis_status_type;

   logic clock = 1'b0;
   logic reset;

   ssrg_req_if req_bus();
   ssrg_rsp_if rsp_bus();
   ssrg_csr_if csr_bus();

   stepper_ramp_step_generator i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_bus),
      .rsp_if (rsp_bus),
      .csr_if (csr_bus)
   );

   always #2 clock = ~clock;

   // Register copies held by the predictor.
   logic                    cfg_hold      = 1'b0;
   logic                    cfg_track     = 1'b0;
   logic [LIMIT_WIDTH-1:0]  cfg_limit     = ssrg_pkg::LIMIT_RESET;
   logic [NUMER_WIDTH-1:0]  cfg_numerator = ssrg_pkg::NUMER_RESET;
   logic [RELOAD_WIDTH-1:0] cfg_ceiling   = ssrg_pkg::CEILING_RESET;

   // Axis state held by the predictor.
   logic [COUNT_WIDTH-1:0]  axis_pending  = '0;
   logic [COUNT_WIDTH-1:0]  axis_position = '0;
   logic [COUNT_WIDTH-1:0]  axis_target   = '0;
   int                      axis_speed    = 0;
   logic                    axis_dir      = 1'b0;
   logic [RELOAD_WIDTH-1:0] axis_reload   = ssrg_pkg::RELOAD_RESET;

   axis_status_type axis_status_q[$];

   bit          allow_idling   = 1'b1;
   int unsigned mismatch_count = 0;
   int unsigned counted_items  = 0;
   int unsigned ready_hold     = 0;
   int unsigned quiet_cycles   = 0;

   // Return the axis to its state after reset.
   task automatic clear_axis();
      axis_pending  = '0;
      axis_position = '0;
      axis_target   = '0;
      axis_speed    = 0;
      axis_dir      = 1'b0;
      axis_reload   = ssrg_pkg::RELOAD_RESET;
   endtask

   // Advance the axis by one accepted command and queue the status it reports.
   task automatic advance_axis(input ssrg_pkg::op_type op,
                               input logic [AMOUNT_WIDTH-1:0] amount);
      axis_status_type want;
      int queued;
      int speed;
      int quotient;
      want.step_pulse = 1'b0;
      if (op == ssrg_pkg::OP_CLEAR) begin
         clear_axis();
      end else if (cfg_hold) begin
         case (op)
            ssrg_pkg::OP_ADD: begin
               axis_target  = axis_target + amount;
               axis_pending = axis_pending + amount;
            end
            ssrg_pkg::OP_TRACK: begin
               if (cfg_track) begin
                  axis_target  = axis_target + 1'b1;
                  axis_pending = axis_pending + 1'b1;
               end
            end
            ssrg_pkg::OP_STEP: begin
               // One unit toward a nonempty queue, else zero -1..1; clamp.
               queued = $signed(axis_pending);
               speed  = axis_speed;
               if (queued == 0) begin
                  if (speed >= -1 && speed <= 1) speed = 0;
               end else if (queued > 0) begin
                  speed = (speed >= queued) ? speed - 1 : speed + 1;
               end else begin
                  speed = (queued >= speed) ? speed + 1 : speed - 1;
               end
               if (speed > int'(cfg_limit)) speed = int'(cfg_limit);
               if (speed < -int'(cfg_limit)) speed = -int'(cfg_limit);
               axis_speed = speed;

               // A nonzero speed issues one step and a new reload.
               if (speed != 0) begin
                  want.step_pulse = 1'b1;
                  if (speed > 0) begin
                     axis_dir      = 1'b1;
                     axis_pending  = axis_pending - 1'b1;
                     axis_position = axis_position + 1'b1;
                  end else begin
                     axis_dir      = 1'b0;
                     axis_pending  = axis_pending + 1'b1;
                     axis_position = axis_position - 1'b1;
                  end
                  quotient = int'(cfg_numerator) / (speed > 0 ? speed : -speed);
                  axis_reload = (quotient > int'(cfg_ceiling)) ? cfg_ceiling
                                                               : RELOAD_WIDTH'(quotient);
               end else begin
                  axis_reload = cfg_ceiling;
               end
            end
            default: begin
            end
         endcase
      end
      want.dir_forward   = axis_dir;
      want.reload_value  = axis_reload;
      want.position_now  = axis_position;
      want.pending_steps = axis_pending;
      want.speed_now     = SPEED_WIDTH'(axis_speed);
      want.target_now    = axis_target;
      axis_status_q.push_back(want);
   endtask

   // Send one command and record its expected status once it is accepted.
   task automatic send_command(input ssrg_pkg::op_type op,
                               input logic [AMOUNT_WIDTH-1:0] amount);
      int unsigned gap;
      @(negedge clock);
      if (allow_idling && $urandom_range(0, 5) == 0) begin
         gap = $urandom_range(1, 13);
         req_bus.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_bus.valid      <= 1'b1;
      req_bus.op         <= op;
      req_bus.add_amount <= amount;
      do @(posedge clock); while (!req_bus.ready);
      counted_items++;
      advance_axis(op, amount);
   endtask

   // Write one register and mirror it in the predictor.
   task automatic write_register(input logic [CSR_INDEX_WIDTH-1:0] index,
                                 input logic [CSR_DATA_WIDTH-1:0] value);
      @(negedge clock);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= index;
      csr_bus.data  <= value;
      do @(posedge clock); while (!csr_bus.ready);
      case (index)
         ssrg_pkg::CSR_HOLD_ENABLE: begin
            cfg_hold = value[0];
            clear_axis();
         end
         ssrg_pkg::CSR_TRACK_ENABLE: cfg_track     = value[0];
         ssrg_pkg::CSR_SPEED_LIMIT:  cfg_limit     = value[LIMIT_WIDTH-1:0];
         ssrg_pkg::CSR_NUMERATOR:    cfg_numerator = value[NUMER_WIDTH-1:0];
         ssrg_pkg::CSR_CEILING:      cfg_ceiling   = value[RELOAD_WIDTH-1:0];
         default: begin
         end
      endcase
      @(negedge clock);
      csr_bus.valid <= 1'b0;
   endtask

   // Hold off the sender until every expected status has been taken.
   task automatic drain_status();
      @(negedge clock);
      req_bus.valid <= 1'b0;
      while (axis_status_q.size() != 0) @(negedge clock);
   endtask

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (got !== want) begin
         $display("%0t: %s expected %h, got %h", $time, name, want, got);
         mismatch_count++;
      end
   endtask

   // Commands while the motor is not held leave the axis alone, but for the clear.
   task automatic test_unheld_commands();
      send_command(ssrg_pkg::OP_STEP, '0);
      send_command(ssrg_pkg::OP_ADD, 32'd7);
      send_command(ssrg_pkg::OP_TRACK, '0);
      send_command(ssrg_pkg::OP_CLEAR, '0);
   endtask

   // Track ticks count only with tracking enabled.
   task automatic test_tracking();
      drain_status();
      write_register(ssrg_pkg::CSR_HOLD_ENABLE, 24'd1);
      send_command(ssrg_pkg::OP_TRACK, '0);
      drain_status();
      write_register(ssrg_pkg::CSR_TRACK_ENABLE, 24'd1);
      send_command(ssrg_pkg::OP_TRACK, '0);
      send_command(ssrg_pkg::OP_TRACK, '0);
   endtask

   // Short moves in both directions, down to a stop at zero speed.
   task automatic test_ramp_profile();
      send_command(ssrg_pkg::OP_ADD, 32'd1);
      repeat (4) send_command(ssrg_pkg::OP_STEP, '0);
      send_command(ssrg_pkg::OP_ADD, -32'sd2);
      repeat (3) send_command(ssrg_pkg::OP_STEP, '0);
   endtask

   // Amount extremes and a pending count that wraps on a step.
   task automatic test_counter_wrap();
      send_command(ssrg_pkg::OP_ADD, 32'h7FFF_FFFF);
      send_command(ssrg_pkg::OP_ADD, 32'h8000_0000);
      send_command(ssrg_pkg::OP_CLEAR, '0);
      send_command(ssrg_pkg::OP_ADD, 32'd5);
      send_command(ssrg_pkg::OP_STEP, '0);
      send_command(ssrg_pkg::OP_STEP, '0);
      send_command(ssrg_pkg::OP_ADD, 32'h7FFF_FFFD);
      send_command(ssrg_pkg::OP_STEP, '0);
   endtask

   // Zero speed limit, a saturated reload and a write past the register list.
   task automatic test_reload_limits();
      drain_status();
      write_register(ssrg_pkg::CSR_SPEED_LIMIT, 24'd0);
      write_register(ssrg_pkg::CSR_NUMERATOR, 24'hFF_FFFF);
      write_register(ssrg_pkg::CSR_CEILING, 24'd100);
      write_register(CSR_UNUSED, 24'h00_0001);
      write_register(ssrg_pkg::CSR_HOLD_ENABLE, 24'd1);
      send_command(ssrg_pkg::OP_ADD, 32'd5);
      send_command(ssrg_pkg::OP_STEP, '0);
      drain_status();
      write_register(ssrg_pkg::CSR_SPEED_LIMIT, 24'd1);
      send_command(ssrg_pkg::OP_STEP, '0);
   endtask

   // Pick a register setting for the next phase, extremes included.
   task automatic configure_random();
      logic [LIMIT_WIDTH-1:0]  limit;
      logic [NUMER_WIDTH-1:0]  numerator;
      logic [RELOAD_WIDTH-1:0] ceiling;
      logic                    hold;
      case ($urandom_range(0, 5))
         0:       limit = LIMIT_WIDTH'(1);
         1:       limit = LIMIT_WIDTH'($urandom_range(2, 8));
         2:       limit = '1;
         3:       limit = LIMIT_WIDTH'($urandom_range(1, 32767));
         4:       limit = '0;
         default: limit = ssrg_pkg::LIMIT_RESET;
      endcase
      case ($urandom_range(0, 3))
         0:       numerator = NUMER_WIDTH'(1);
         1:       numerator = '1;
         2:       numerator = NUMER_WIDTH'($urandom_range(1, 24'hFF_FFFF));
         default: numerator = NUMER_WIDTH'($urandom_range(1, 400000));
      endcase
      case ($urandom_range(0, 2))
         0:       ceiling = RELOAD_WIDTH'(1);
         1:       ceiling = '1;
         default: ceiling = RELOAD_WIDTH'($urandom_range(1, 65535));
      endcase
      hold = ($urandom_range(0, 7) != 0);
      write_register(ssrg_pkg::CSR_SPEED_LIMIT, CSR_DATA_WIDTH'(limit));
      write_register(ssrg_pkg::CSR_NUMERATOR, numerator);
      write_register(ssrg_pkg::CSR_CEILING, CSR_DATA_WIDTH'(ceiling));
      write_register(ssrg_pkg::CSR_TRACK_ENABLE, CSR_DATA_WIDTH'($urandom_range(0, 1)));
      if (hold != cfg_hold || $urandom_range(0, 1) == 1)
         write_register(ssrg_pkg::CSR_HOLD_ENABLE, CSR_DATA_WIDTH'(hold));
   endtask

   // One move: queue a short distance, then tick until it should settle.
   task automatic run_move();
      int distance;
      int ticks;
      distance = int'($urandom_range(0, 60)) - 30;
      send_command(ssrg_pkg::OP_ADD, distance);
      ticks = (distance < 0 ? -distance : distance) + int'($urandom_range(2, 6));
      repeat (ticks) begin
         if ($urandom_range(0, 19) == 0)
            send_command(ssrg_pkg::OP_ADD, int'($urandom_range(0, 20)) - 10);
         else
            send_command(ssrg_pkg::OP_STEP, '0);
      end
   endtask

   // Any command with any amount, including full-range adds.
   task automatic send_noise();
      case ($urandom_range(0, 4))
         0:       send_command(ssrg_pkg::OP_ADD, $urandom());
         1:       send_command(ssrg_pkg::OP_TRACK, $urandom());
         2:       send_command(ssrg_pkg::OP_CLEAR, $urandom());
         3:       send_command(ssrg_pkg::OP_STEP, $urandom());
         default: send_command(ssrg_pkg::OP_ADD,
                               $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000);
      endcase
   endtask

   // Phases of moves and noise, each under a fresh register setting.
   task automatic test_random_profiles();
      int unsigned phase_items;
      int unsigned moves_left;
      counted_items = 0;
      while (counted_items < RANDOM_ITEMS) begin
         drain_status();
         if (counted_items >= RANDOM_ITEMS - CALM_ITEMS) allow_idling = 1'b0;
         configure_random();
         phase_items = $urandom_range(40, 80);
         moves_left  = phase_items / 8 + 1;
         while (moves_left != 0 && counted_items < RANDOM_ITEMS) begin
            moves_left--;
            if ($urandom_range(0, 9) < 7) run_move();
            else send_noise();
         end
      end
   endtask

   // Receiver stalls come in bursts, started at random while idling is allowed.
   always @(negedge clock) begin
      if (ready_hold != 0) begin
         ready_hold--;
         rsp_bus.ready <= 1'b0;
      end else if (allow_idling && $urandom_range(0, 9) == 0) begin
         ready_hold = $urandom_range(0, 12);
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= 1'b1;
      end
   end

   // Compare each status transaction with the oldest expectation.
   always @(posedge clock) begin : status_check
      axis_status_type want;
      axis_status_type got;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (axis_status_q.size() == 0) begin
            $display("%0t: status transaction expected none, got %h", $time,
                     rsp_bus.position_now);
            mismatch_count++;
         end else begin
            want = axis_status_q.pop_front();
            got.step_pulse    = rsp_bus.step_pulse;
            got.dir_forward   = rsp_bus.dir_forward;
            got.reload_value  = rsp_bus.reload_value;
            got.position_now  = rsp_bus.position_now;
            got.pending_steps = rsp_bus.pending_steps;
            got.speed_now     = rsp_bus.speed_now;
            got.target_now    = rsp_bus.target_now;
            check_field("step_pulse", 32'(want.step_pulse), 32'(got.step_pulse));
            check_field("dir_forward", 32'(want.dir_forward), 32'(got.dir_forward));
            check_field("reload_value", 32'(want.reload_value), 32'(got.reload_value));
            check_field("position_now", want.position_now, got.position_now);
            check_field("pending_steps", want.pending_steps, got.pending_steps);
            check_field("speed_now", 32'(want.speed_now), 32'(got.speed_now));
            check_field("target_now", want.target_now, got.target_now);
         end
      end
   end

   // End the run when no transaction moves on any channel for too long.
   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)
          || (csr_bus.valid && csr_bus.ready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles == QUIET_LIMIT) begin
            $display("stepper_ramp_step_generator_tb NOT OK");
            $finish;
         end
      end
   end

   // Reset, directed tests, random phases, then the final verdict.
   initial begin
      reset              = 1'b1;
      req_bus.valid      = 1'b0;
      req_bus.op         = ssrg_pkg::OP_STEP;
      req_bus.add_amount = '0;
      rsp_bus.ready      = 1'b0;
      csr_bus.valid      = 1'b0;
      csr_bus.index      = ssrg_pkg::CSR_HOLD_ENABLE;
      csr_bus.data       = '0;
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_unheld_commands();
      test_tracking();
      test_ramp_profile();
      test_counter_wrap();
      test_reload_limits();
      test_random_profiles();

      drain_status();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && axis_status_q.size() == 0)
         $display("stepper_ramp_step_generator_tb OK");
      else
         $display("stepper_ramp_step_generator_tb NOT OK");
      $finish;
   end

endmodule

`default_nettype wire

// File: stepper_ramp_step_generator.f
src/ssrg_pkg.sv
src/ssrg_req_if.sv
src/ssrg_rsp_if.sv
src/ssrg_csr_if.sv
src/ssrg_div.sv
src/stepper_ramp_step_generator.sv
tb/sv/stepper_ramp_step_generator_tb.sv
